### design/mdcc_pkg.sv
// Package for the masked depth change classifier.
// Holds field widths, verdict codes and register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdcc_pkg;

	localparam int unsigned DepthW = 16;
	localparam int unsigned ThrW   = 16;
	localparam int unsigned AbsW   = 40;
	localparam int unsigned SgnW   = 41;
	localparam int unsigned CntW   = 24;
	localparam int unsigned ProdW  = ThrW + CntW;
	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [1:0] {
		VERDICT_PRESENT  = 2'd0,
		VERDICT_OCCLUDED = 2'd1,
		VERDICT_ABSENT   = 2'd2
	} verdict_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PRESENT_THR  = 2'd0,
		REG_OCCLUDED_THR = 2'd1,
		REG_OVERLAP_TOL  = 2'd2
	} cfg_reg_t;

	localparam logic [ThrW-1:0] PresentThrReset  = 16'd160;
	localparam logic [ThrW-1:0] OccludedThrReset = 16'd150;
	localparam logic [ThrW-1:0] OverlapTolReset  = 16'd50;

endpackage

`default_nettype wire

### design/masked_depth_change_classifier.sv
// Masked depth change classifier: pixel stream in, overlap bit and verdict out.
// Depends on mdcc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel per item: mask bit,
//   projected depth, scene depth (mm) and an end-of-object flag. The output
//   channel (out_valid / out_stall) returns one item per pixel: the overlap
//   bit, and on the end-of-object pixel a verdict with verdict_valid set.
//   Pixel items of one object follow each other; the object closes on the
//   pixel with object_end set and the accumulators start over after it.
//   Throughput: one item per cycle while no result is stalled. The pipeline
//   is four registers deep (input, accumulate, multiply, result), and a pixel
//   passes through them in that order to reach out_valid. The loop that sets
//   the rate is the accumulator update in stage two.
//   When the receiver stalls a held result, the whole pipeline freezes and
//   in_stall is raised in the same cycle; no item is lost or repeated.
//   Reset (arst_n low) empties the pipeline, clears the accumulators and
//   loads the register defaults (present 160, occluded 150, tolerance 50).
//   Write configuration through cfg_write / cfg_index / cfg_data only while
//   the pipeline is empty; index 3 is ignored.
`timescale 1ns / 1ps
`default_nettype none

module masked_depth_change_classifier #(
	parameter int unsigned MAX_OBJECT_PIXELS = 16777215
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write port
	input  wire logic                         cfg_write,
	input  wire logic [mdcc_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [mdcc_pkg::ThrW-1:0]    cfg_data,
	// pixel input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         mask_bit,
	input  wire logic [mdcc_pkg::DepthW-1:0]  projected_depth,
	input  wire logic [mdcc_pkg::DepthW-1:0]  scene_depth,
	input  wire logic                         object_end,
	// result output channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              overlap_bit,
	output logic [1:0]                        verdict,
	output logic                              verdict_valid
);
	import mdcc_pkg::*;

	// Count saturates at the parameter or at the full counter, whichever is less.
	localparam logic [CntW-1:0] CountCap =
		(MAX_OBJECT_PIXELS < (2 ** CntW - 1)) ? CntW'(MAX_OBJECT_PIXELS) : {CntW{1'b1}};

	localparam logic [SgnW-1:0] SgnMax = {1'b0, {(SgnW-1){1'b1}}};
	localparam logic [SgnW-1:0] SgnMin = {1'b1, {(SgnW-1){1'b0}}};

	// ---------------------------------------------------------------- config
	logic [ThrW-1:0] present_thr_q;
	logic [ThrW-1:0] occluded_thr_q;
	logic [ThrW-1:0] overlap_tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_thr_q  <= PresentThrReset;
			occluded_thr_q <= OccludedThrReset;
			overlap_tol_q  <= OverlapTolReset;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PRESENT_THR:  present_thr_q  <= cfg_data;
				REG_OCCLUDED_THR: occluded_thr_q <= cfg_data;
				REG_OVERLAP_TOL:  overlap_tol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ flow control
	// The whole pipeline moves as one; it holds only while a result is stalled.
	logic advance;
	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	// ------------------------------------------------------- stage 1: input
	logic              valid_s1;
	logic              mask_s1;
	logic              last_s1;
	logic [DepthW-1:0] proj_s1;
	logic [DepthW-1:0] scene_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			mask_s1  <= mask_bit;
			last_s1  <= object_end;
			proj_s1  <= projected_depth;
			scene_s1 <= scene_depth;
		end
	end

	// ---------------------------------------------- stage 2: difference, sums
	logic [DepthW:0]   diff;       // two's complement, one bit wider than depth
	logic [DepthW:0]   diff_neg;
	logic [DepthW-1:0] abs_diff;
	logic [AbsW:0]     abs_wide;
	logic [AbsW-1:0]   abs_next;
	logic [SgnW:0]     sgn_wide;
	logic [SgnW-1:0]   sgn_next;
	logic [CntW-1:0]   cnt_next;
	logic              overlap;

	logic [AbsW-1:0] abs_sum_q;
	logic [SgnW-1:0] sgn_sum_q;
	logic [CntW-1:0] count_q;

	always_comb begin
		// zero scene depth outside the mask
		diff     = {1'b0, proj_s1} - {1'b0, (mask_s1 ? scene_s1 : {DepthW{1'b0}})};
		diff_neg = -diff;
		abs_diff = diff[DepthW] ? diff_neg[DepthW-1:0] : diff[DepthW-1:0];

		abs_wide = {1'b0, abs_sum_q} + {{(AbsW+1-DepthW){1'b0}}, abs_diff};
		abs_next = abs_wide[AbsW] ? {AbsW{1'b1}} : abs_wide[AbsW-1:0];

		sgn_wide = {sgn_sum_q[SgnW-1], sgn_sum_q} + {{(SgnW-DepthW){diff[DepthW]}}, diff};
		// clamp on two's complement overflow
		if (sgn_wide[SgnW] != sgn_wide[SgnW-1]) begin
			sgn_next = sgn_wide[SgnW] ? SgnMin : SgnMax;
		end else begin
			sgn_next = sgn_wide[SgnW-1:0];
		end

		cnt_next = (mask_s1 && (count_q < CountCap)) ? count_q + 1'b1 : count_q;
		overlap  = mask_s1 && (abs_diff < overlap_tol_q);
	end

	logic            valid_s2;
	logic            last_s2;
	logic            overlap_s2;
	logic [AbsW-1:0] abs_s2;
	logic [SgnW-1:0] sgn_s2;
	logic [CntW-1:0] cnt_s2;

	// Accumulators: take the new sums, or clear after the closing pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_sum_q <= '0;
			sgn_sum_q <= '0;
			count_q   <= '0;
			valid_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (last_s1) begin
					abs_sum_q <= '0;
					sgn_sum_q <= '0;
					count_q   <= '0;
				end else begin
					abs_sum_q <= abs_next;
					sgn_sum_q <= sgn_next;
					count_q   <= cnt_next;
				end
			end
		end
	end

	// Snapshot including the current pixel, for the verdict.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			last_s2    <= last_s1;
			overlap_s2 <= overlap;
			abs_s2     <= abs_next;
			sgn_s2     <= sgn_next;
			cnt_s2     <= cnt_next;
		end
	end

	// ------------------------------------------- stage 3: threshold products
	logic             valid_s3;
	logic             last_s3;
	logic             overlap_s3;
	logic             nonempty_s3;
	logic [AbsW-1:0]  abs_s3;
	logic [SgnW-1:0]  sgn_s3;
	logic [ProdW-1:0] present_lim_s3;
	logic [ProdW-1:0] occluded_lim_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			last_s3         <= last_s2;
			overlap_s3      <= overlap_s2;
			nonempty_s3     <= (cnt_s2 != '0);
			abs_s3          <= abs_s2;
			sgn_s3          <= sgn_s2;
			present_lim_s3  <= {{CntW{1'b0}}, present_thr_q} * {{ThrW{1'b0}}, cnt_s2};
			occluded_lim_s3 <= {{CntW{1'b0}}, occluded_thr_q} * {{ThrW{1'b0}}, cnt_s2};
		end
	end

	// ---------------------------------------------- stage 4: verdict, result
	verdict_t verdict_d;

	always_comb begin
		priority if (!nonempty_s3) begin
			verdict_d = VERDICT_ABSENT;
		end else if (abs_s3 < present_lim_s3) begin
			verdict_d = VERDICT_PRESENT;
		end else if ($signed(sgn_s3) > $signed({1'b0, occluded_lim_s3})) begin
			verdict_d = VERDICT_OCCLUDED;
		end else begin
			verdict_d = VERDICT_ABSENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s3;
		end
	end

	// Non-closing pixels report the present code with verdict_valid low.
	always_ff @(posedge clk) begin
		if (advance && valid_s3) begin
			overlap_bit   <= overlap_s3;
			verdict_valid <= last_s3;
			verdict       <= last_s3 ? verdict_d : VERDICT_PRESENT;
		end
	end

endmodule

`default_nettype wire

### design/mdcc_checker.sv
// Port-level checker for the masked depth change classifier, with its bind.
// Depends on mdcc_pkg and masked_depth_change_classifier.
`timescale 1ns / 1ps
`default_nettype none

module mdcc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       overlap_bit,
	input wire logic [1:0] verdict,
	input wire logic       verdict_valid
);
	import mdcc_pkg::*;

	// a held result must freeze the input side
	a_stall_propagates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("result held but input still open");

	// with nothing held, the input is open
	a_open_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled without a held result");

	// pixels that do not close an object carry the zero verdict code
	a_idle_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !verdict_valid |-> verdict == VERDICT_PRESENT)
		else $error("verdict code on a non-closing pixel");

	// a stalled result holds
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(overlap_bit)
			&& $stable(verdict) && $stable(verdict_valid))
		else $error("stalled result changed");

endmodule

bind masked_depth_change_classifier mdcc_checker u_mdcc_checker (.*);

`default_nettype wire

### verif/masked_depth_change_classifier_tb.sv
// Testbench for masked_depth_change_classifier: directed corners, then random objects under
// several register settings, every result checked against an in-bench predictor.
// Depends on mdcc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module masked_depth_change_classifier_tb;
	import mdcc_pkg::*;

	// Saturation points of the accumulators and the pixel count cap.
	localparam longint ABS_SAT  = 64'h0000_00FF_FFFF_FFFF;
	localparam longint SGN_HI   = 64'h0000_00FF_FFFF_FFFF;
	localparam longint SGN_LO   = -64'sh0000_0100_0000_0000;
	localparam longint MAX_PIX  = 16777215;
	localparam longint CNT_CAP  = (MAX_PIX < 64'hFF_FFFF) ? MAX_PIX : 64'hFF_FFFF;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;

	typedef struct packed {
		logic              mask;
		logic [DepthW-1:0] projected;
		logic [DepthW-1:0] scene;
		logic              closing;
	} pixel_t;

	typedef struct packed {
		logic     overlap;
		verdict_t verdict;
		logic     closes;
	} depth_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = REG_PRESENT_THR;
	logic [ThrW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mask_bit = 1'b0;
	logic [DepthW-1:0] projected_depth = '0;
	logic [DepthW-1:0] scene_depth = '0;
	logic object_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic overlap_bit;
	logic [1:0] verdict;
	logic verdict_valid;

	masked_depth_change_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mask_bit(mask_bit),
		.projected_depth(projected_depth),
		.scene_depth(scene_depth),
		.object_end(object_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.overlap_bit(overlap_bit),
		.verdict(verdict),
		.verdict_valid(verdict_valid)
	);

	// 8 ns clock: four high, four low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the register file, updated as the writes go out.
	logic [ThrW-1:0] present_thr  = PresentThrReset;
	logic [ThrW-1:0] occluded_thr = OccludedThrReset;
	logic [ThrW-1:0] overlap_tol  = OverlapTolReset;

	// Predictor copy of the per-object accumulators.
	logic [AbsW-1:0]        abs_acc  = '0;
	logic signed [SgnW-1:0] sgn_acc  = '0;
	logic [CntW-1:0]        mask_cnt = '0;

	pixel_t        pixel_backlog[$];
	depth_result_t predicted[$];

	int  errors = 0;
	int  pixels_taken = 0;
	int  results_seen = 0;
	int  stall_cycles = 0;
	int  cycle_count = 0;
	int  verdict_tally[3] = '{0, 0, 0};
	logic receiver_hold = 1'b0;

	// Fold one pixel into the accumulators and work out the item it must produce.
	function automatic depth_result_t classify_pixel(input pixel_t px);
		longint diff, mag, sum_abs, sum_sgn, n;
		depth_result_t r;
		diff = longint'(px.projected) - (px.mask ? longint'(px.scene) : 64'sd0);
		mag = (diff < 0) ? -diff : diff;
		// Saturate both sums; the verdict sees the clamped values.
		sum_abs = longint'(abs_acc) + mag;
		abs_acc = (sum_abs > ABS_SAT) ? ABS_SAT[AbsW-1:0] : sum_abs[AbsW-1:0];
		sum_sgn = longint'(sgn_acc) + diff;
		if (sum_sgn > SGN_HI)
			sum_sgn = SGN_HI;
		if (sum_sgn < SGN_LO)
			sum_sgn = SGN_LO;
		sgn_acc = sum_sgn[SgnW-1:0];
		if (px.mask && longint'(mask_cnt) < CNT_CAP)
			mask_cnt = mask_cnt + 1'b1;

		r.overlap = px.mask && (mag < longint'(overlap_tol));
		r.verdict = VERDICT_PRESENT;
		r.closes = 1'b0;
		if (px.closing) begin
			n = longint'(mask_cnt);
			r.verdict = VERDICT_ABSENT;
			// An empty object stays absent no matter what the sums hold.
			if (n > 0) begin
				if (longint'(abs_acc) < longint'(present_thr) * n)
					r.verdict = VERDICT_PRESENT;
				else if (longint'(sgn_acc) > longint'(occluded_thr) * n)
					r.verdict = VERDICT_OCCLUDED;
			end
			r.closes = 1'b1;
			abs_acc = '0;
			sgn_acc = '0;
			mask_cnt = '0;
		end
		return r;
	endfunction

	// Wait cycles before the next item; flip in and out of back-to-back stretches.
	function automatic int pick_wait(inout bit quiet);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		if (quiet)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch at result %0d: %s", $realtime, results_seen, what);
		errors++;
	endtask

	// Driver: offer backlog pixels, hold each until taken, predict on acceptance.
	pixel_t offered;
	int gap_left = 0;
	bit send_quiet = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted.insert(predicted.size(), classify_pixel(offered));
				pixels_taken++;
			end
			if (in_valid && in_stall)
				stall_cycles++;
			// Advance only when nothing is held or the held item just went through.
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pixel_backlog.size() != 0) begin
					offered = pixel_backlog.pop_front();
					mask_bit <= offered.mask;
					projected_depth <= offered.projected;
					scene_depth <= offered.scene;
					object_end <= offered.closing;
					in_valid <= 1'b1;
					// Keep pushing while the receiver is held off so the pipe fills.
					gap_left = receiver_hold ? 0 : pick_wait(send_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: take results, compare each with the oldest prediction, stall at random.
	depth_result_t want;
	int stall_left = 0;
	bit recv_quiet = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted.size() == 0) begin
					report_mismatch("result with no pixel outstanding");
				end else begin
					want = predicted.pop_front();
					if (overlap_bit !== want.overlap)
						report_mismatch($sformatf("overlap_bit %b, expected %b",
							overlap_bit, want.overlap));
					if (verdict_valid !== want.closes)
						report_mismatch($sformatf("verdict_valid %b, expected %b",
							verdict_valid, want.closes));
					if (verdict !== want.verdict)
						report_mismatch($sformatf("verdict %0d, expected %s",
							verdict, want.verdict.name()));
					if (want.closes)
						verdict_tally[want.verdict]++;
				end
				results_seen++;
				stall_left = pick_wait(recv_quiet);
			end
			if (receiver_hold) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Long receiver hold-off once traffic is flowing, counted here in cycles.
	initial begin
		wait (pixels_taken >= 150);
		@(posedge clk);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	// Watchdog: end the run if the traffic never drains.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_pixel(input bit m, input int p, input int s, input bit e);
		pixel_t px;
		px.mask = m;
		px.projected = p[DepthW-1:0];
		px.scene = s[DepthW-1:0];
		px.closing = e;
		pixel_backlog.insert(pixel_backlog.size(), px);
	endtask

	// Queue one whole object whose pixels lean toward one verdict, or are plain noise.
	task automatic queue_random_object(output int len);
		int style, spread, base, sc, i;
		bit m;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
		style = $urandom_range(0, 9);
		spread = $urandom_range(0, 400);
		for (i = 0; i < len; i++) begin
			base = $urandom_range(0, 65535);
			if (style == 9)
				m = 1'b0;
			else if (style == 8)
				m = 1'($urandom_range(0, 1));
			else
				m = ($urandom_range(0, 9) != 0);
			case (style)
				0, 1, 2, 3: sc = base + int'($urandom_range(0, 2 * spread)) - spread;
				4, 5:       sc = base - int'($urandom_range(100, 3000));
				6, 7:       sc = base + int'($urandom_range(100, 3000));
				default:    sc = $urandom_range(0, 65535);
			endcase
			if (sc < 0)
				sc = 0;
			if (sc > 65535)
				sc = 65535;
			push_pixel(m, base, sc, i == len - 1);
		end
	endtask

	// Settle at the falling edge so the driver and monitor updates are all visible.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pixel_backlog.size() != 0 || in_valid || predicted.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [ThrW-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PRESENT_THR:  present_thr = val;
			REG_OCCLUDED_THR: occluded_thr = val;
			REG_OVERLAP_TOL:  overlap_tol = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_thresholds(input int p, input int o, input int t);
		wait_drained();
		write_reg(REG_PRESENT_THR, p[ThrW-1:0]);
		write_reg(REG_OCCLUDED_THR, o[ThrW-1:0]);
		write_reg(REG_OVERLAP_TOL, t[ThrW-1:0]);
	endtask

	task automatic run_random(input int p, input int o, input int t, input int count);
		int queued, len;
		set_thresholds(p, o, t);
		queued = 0;
		while (queued < count) begin
			queue_random_object(len);
			queued += len;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset thresholds: present, empty, full-scale swings, the present boundary,
		// the overlap boundary, and unmasked pixels still feeding the sums.
		push_pixel(1, 1000, 1000, 1);
		push_pixel(0, 0, 65535, 1);
		push_pixel(1, 65535, 0, 0);
		push_pixel(1, 0, 65535, 1);
		push_pixel(1, 2000, 1840, 1);
		push_pixel(1, 1000, 950, 0);
		push_pixel(1, 1000, 1049, 1);
		push_pixel(0, 65535, 0, 0);
		push_pixel(1, 100, 100, 1);
		push_pixel(0, 500, 7, 0);
		push_pixel(0, 65535, 65535, 1);

		// Zero present threshold and tolerance: the occluded boundary on both sides.
		set_thresholds(0, 150, 0);
		push_pixel(1, 1150, 1000, 1);
		push_pixel(1, 1151, 1000, 1);
		push_pixel(1, 0, 0, 1);

		// Everything at full scale: strict compares at the top of the range.
		set_thresholds(65535, 65535, 65535);
		push_pixel(1, 65535, 0, 1);
		push_pixel(1, 65534, 0, 1);
		push_pixel(0, 1, 5, 1);

		run_random(PresentThrReset, OccludedThrReset, OverlapTolReset, 150);
		run_random(0, 0, 0, 100);
		run_random(65535, 65535, 65535, 80);
		run_random($urandom_range(0, 600), $urandom_range(0, 600), $urandom_range(0, 600), 150);
		run_random($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), 100);

		wait_drained();
		repeat (12) @(posedge clk);
		if (predicted.size() != 0)
			report_mismatch($sformatf("%0d predicted results never came", predicted.size()));

		$display("Checked %0d pixels; verdicts: %0d present, %0d occluded, %0d absent.",
			results_seen, verdict_tally[VERDICT_PRESENT], verdict_tally[VERDICT_OCCLUDED],
			verdict_tally[VERDICT_ABSENT]);
		$display("Eight threshold phases, extremes included; sender stalled %0d cycles.",
			stall_cycles);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
